### hw/rtl/magic_length_frame_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MLFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// next-cycle implication, disabled while in reset
`define MLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

### hw/rtl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

	localparam int unsigned HDR_BYTES   = 12;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned MAXLEN_W    = 17;
	localparam int unsigned HCNT_W      = 4;

	localparam logic [31:0]         MAGIC_RESET  = 32'h3046_5349;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 17'd1024;

	// header byte positions (magic counted in)
	localparam logic [HCNT_W-1:0] HPOS_LEN_LO  = 4'd4;
	localparam logic [HCNT_W-1:0] HPOS_LEN_HI  = 4'd5;
	localparam logic [HCNT_W-1:0] HPOS_FLAG_LO = 4'd6;
	localparam logic [HCNT_W-1:0] HPOS_FLAG_HI = 4'd7;
	localparam logic [HCNT_W-1:0] HPOS_LAST    = 4'd11;
	localparam logic [HCNT_W-1:0] HPOS_DONE    = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC  = 1'b0,
		CFG_MAXLEN = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT0   = 3'd0,
		PH_HUNT1   = 3'd1,
		PH_HUNT2   = 3'd2,
		PH_HUNT3   = 3'd3,
		PH_HEADER  = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef struct packed {
		logic [31:0]         magic_word;
		logic [MAXLEN_W-1:0] max_frame_bytes;
	} mlfd_cfg_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic [15:0] payload_index;
		logic        frame_last;
		logic [15:0] frame_length;
		logic [15:0] flag_word;
	} mlfd_result_t;

endpackage

`default_nettype wire

### hw/rtl/magic_length_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Magic / length-prefixed frame deframer
// Hunts a 4-byte start pattern, parses a 12-byte header and streams out the
// payload bytes tagged with length, flag, index and a last marker.
// ----------------------------------------------------------------------------
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid/in_ready, rx_byte           | sink
//   out     | out_valid/out_ready, payload fields  | source
//   cfg     | cfg_valid/cfg_ready, cfg_index/data  | sink
//
// One byte per cycle while the sink keeps up. A byte is registered on
// acceptance, decoded from there, and its result beat (if any) registered.
// The result register parts input from output: a byte is taken while a result
// waits, and a stalled sink backs up only once the input stage is also full.
// Reset: magic 0x30465349, size limit 1024, hunting for magic byte 0.
// cfg_ready is always high; a write applies from the next decoded byte.
//
`default_nettype none

module magic_length_frame_deframer_core (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [7:0]                        rx_byte,

	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [7:0]                        payload_byte,
	output logic                              payload_valid,
	output logic [15:0]                       payload_index,
	output logic                              frame_last,
	output logic [15:0]                       frame_length,
	output logic [15:0]                       flag_word,

	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [mlfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [mlfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mlfd_pkg::*;

	mlfd_cfg_t    cfg;
	mlfd_result_t res;
	mlfd_result_t out_res;
	logic         res_valid;
	logic         adv;

	mlfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// byte register + frame FSM; advances whenever the result reg has room
	mlfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	mlfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign payload_byte  = out_res.payload_byte;
	assign payload_valid = out_res.payload_valid;
	assign payload_index = out_res.payload_index;
	assign frame_last    = out_res.frame_last;
	assign frame_length  = out_res.frame_length;
	assign flag_word     = out_res.flag_word;

endmodule

`default_nettype wire

### hw/rtl/mlfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the magic pattern and the frame size limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_cfg_regs (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [mlfd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [mlfd_pkg::CFG_DATA_W-1:0]       cfg_data,
	output mlfd_pkg::mlfd_cfg_t                   cfg
);
	import mlfd_pkg::*;

	mlfd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word      <= MAGIC_RESET;
			cfg_q.max_frame_bytes <= MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAGIC:  cfg_q.magic_word      <= cfg_data[31:0];
				CFG_MAXLEN: cfg_q.max_frame_bytes <= cfg_data[MAXLEN_W-1:0];
				default:    cfg_q                 <= cfg_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mlfd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Input byte register, frame state machine and result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_parser (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [7:0]             rx_byte,
	input  mlfd_pkg::mlfd_cfg_t    cfg,
	input  wire                    adv,
	output logic                   res_valid,
	output mlfd_pkg::mlfd_result_t res
);
	import mlfd_pkg::*;

	logic [7:0]        byte_s1;
	logic              vld_s1;
	logic              fire;

	phase_t            phase_q, phase_d;
	logic [HCNT_W-1:0] hcnt_q, hcnt_d;
	logic [15:0]       len_q, len_d;
	logic [15:0]       flag_q, flag_d;
	logic [15:0]       pcnt_q, pcnt_d;

	logic              oversize;
	logic              pay_last;

	// byte in stage 1 is consumed when the result register can take a beat
	assign fire     = vld_s1 && adv;
	assign in_ready = !vld_s1 || adv;

	assign oversize = ({1'b0, len_q} + MAXLEN_W'(HDR_BYTES)) > cfg.max_frame_bytes;
	assign pay_last = ({1'b0, pcnt_q} + 17'd1) >= {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			hcnt_q  <= '0;
			len_q   <= '0;
			flag_q  <= '0;
			pcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			len_q   <= len_d;
			flag_q  <= flag_d;
			pcnt_q  <= pcnt_d;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		len_d   = len_q;
		flag_d  = flag_q;
		pcnt_d  = pcnt_q;
		if (fire) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (byte_s1 == cfg.magic_word[15:8]) begin
						phase_d = PH_HUNT2;
						hcnt_d  = 4'd2;
					end else begin
						phase_d = PH_HUNT0;
						hcnt_d  = '0;
					end
				end
				PH_HUNT2: begin
					if (byte_s1 == cfg.magic_word[23:16]) begin
						phase_d = PH_HUNT3;
						hcnt_d  = 4'd3;
					end else begin
						phase_d = PH_HUNT0;
						hcnt_d  = '0;
					end
				end
				PH_HUNT3: begin
					if (byte_s1 == cfg.magic_word[31:24]) begin
						phase_d = PH_HEADER;
						hcnt_d  = 4'd4;
					end else begin
						phase_d = PH_HUNT0;
						hcnt_d  = '0;
					end
				end
				PH_HEADER: begin
					priority if (hcnt_q == HPOS_LEN_LO) begin
						len_d[7:0] = byte_s1;
					end else if (hcnt_q == HPOS_LEN_HI) begin
						len_d[15:8] = byte_s1;
					end else if (hcnt_q == HPOS_FLAG_LO) begin
						flag_d[7:0] = byte_s1;
					end else if (hcnt_q == HPOS_FLAG_HI) begin
						flag_d[15:8] = byte_s1;
					end else begin
						len_d = len_q;
					end
					if (hcnt_q != HPOS_LAST) begin
						hcnt_d = hcnt_q + 4'd1;
					end else begin
						hcnt_d = HPOS_DONE;
						pcnt_d = '0;
						if (oversize || (len_q == '0)) begin
							phase_d = PH_HUNT0;
							hcnt_d  = '0;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (pay_last) begin
						pcnt_d  = '0;
						phase_d = PH_HUNT0;
						hcnt_d  = '0;
					end else begin
						pcnt_d = pcnt_q + 16'd1;
					end
				end
				default: begin
					// hunting for magic byte 0
					if (byte_s1 == cfg.magic_word[7:0]) begin
						phase_d = PH_HUNT1;
						hcnt_d  = 4'd1;
					end else begin
						phase_d = PH_HUNT0;
						hcnt_d  = '0;
					end
				end
			endcase
		end
	end

	// result decode
	always_comb begin
		res_valid         = 1'b0;
		res.payload_byte  = byte_s1;
		res.payload_valid = 1'b1;
		res.payload_index = pcnt_q;
		res.frame_last    = pay_last;
		res.frame_length  = len_q;
		res.flag_word     = flag_q;
		if (fire && (phase_q == PH_PAYLOAD)) begin
			res_valid = 1'b1;
		end else if (fire && (phase_q == PH_HEADER) && (hcnt_q == HPOS_LAST)
				&& !oversize && (len_q == '0)) begin
			// empty frame marker
			res_valid         = 1'b1;
			res.payload_byte  = '0;
			res.payload_valid = 1'b0;
			res.payload_index = '0;
			res.frame_last    = 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mlfd_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_out_reg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     res_valid,
	input  mlfd_pkg::mlfd_result_t  res,
	output logic                    adv,
	output logic                    out_valid,
	input  wire                     out_ready,
	output mlfd_pkg::mlfd_result_t  out_res
);
	import mlfd_pkg::*;

	logic         valid_q;
	mlfd_result_t res_q;

	assign adv       = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mlfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magic_length_frame_deframer_core_assert.svh"

module mlfd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [7:0]  payload_byte,
	input wire        payload_valid,
	input wire [15:0] payload_index,
	input wire        frame_last,
	input wire [15:0] frame_length
);

	// stalled beat holds
	`MLFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(payload_index))

	// empty marker is a lone, zeroed, final beat of a zero-length frame
	`MLFD_ASSERT_IMPL(a_empty_marker, clk, arst_n, out_valid && !payload_valid, frame_last && (payload_byte == 8'd0) && (payload_index == 16'd0) && (frame_length == 16'd0))

	// last payload byte sits at length - 1
	`MLFD_ASSERT_IMPL(a_last_index, clk, arst_n, out_valid && payload_valid && frame_last, ({1'b0, payload_index} + 17'd1) == {1'b0, frame_length})

	// non-final payload byte lies inside the frame
	`MLFD_ASSERT_IMPL(a_mid_index, clk, arst_n, out_valid && payload_valid && !frame_last, ({1'b0, payload_index} + 17'd1) < {1'b0, frame_length})

endmodule

bind magic_length_frame_deframer_core mlfd_checker u_mlfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_byte  (payload_byte),
	.payload_valid (payload_valid),
	.payload_index (payload_index),
	.frame_last    (frame_last),
	.frame_length  (frame_length)
);

`default_nettype wire
